// ===== hdl/sine_cosine_poly_fixed_unit_assert.svh =====
// ----------------------------------------------------------------------------
// sine_cosine_poly_fixed_unit assertion macros
// shared property forms for the sine / cosine unit checks
// ----------------------------------------------------------------------------
`ifndef SINE_COSINE_POLY_FIXED_UNIT_ASSERT_SVH
`define SINE_COSINE_POLY_FIXED_UNIT_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define SCPF_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define SCPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/scpf_pkg.sv =====
// ----------------------------------------------------------------------------
// scpf_pkg
// shared widths, constants and types of the sine / cosine unit
// ----------------------------------------------------------------------------
package scpf_pkg;

  localparam int ANGLE_W = 25;
  localparam int COEF_W  = 22;
  localparam int OUT_W   = 22;
  localparam int MAG_W   = 31;
  localparam int NANO_W  = 35;

  // angle handling in micro-radians
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT   = 25'sd9424777;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_MICRO = 25'sd1570796;
  // smallest micro angle whose nano value lies above pi
  localparam logic signed [ANGLE_W-1:0] PI_MICRO_UP   = 25'sd3141593;
  // 2pi steps as seen after truncation back to micro units
  localparam logic signed [ANGLE_W-1:0] TWO_PI_LO     = 25'sd6283185;
  localparam logic signed [ANGLE_W-1:0] TWO_PI_HI     = 25'sd6283186;

  // angle handling in nano-radians
  localparam logic signed [NANO_W-1:0] NANO_PER_MICRO = 35'sd1000;
  localparam logic signed [NANO_W-1:0] PI_NANO        = 35'sd3141592654;
  localparam logic signed [NANO_W-1:0] HALF_PI_NANO   = 35'sd1570796327;
  localparam logic signed [NANO_W-1:0] TWO_PI_NANO    = 35'sd6283185307;

  localparam logic [29:0] NANO_PER_UNIT  = 30'd1000000000;
  localparam logic [19:0] MICRO_PER_UNIT = 20'd1000000;
  localparam logic [OUT_W-1:0] OUT_LIMIT = 22'd1048576;

  // coefficient reset values, Q20
  localparam logic signed [COEF_W-1:0] COEF_CUBIC_RST   = 22'sd1048429;
  localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST  = -22'sd174021;
  localparam logic signed [COEF_W-1:0] COEF_QUARTIC_RST = 22'sd7979;

  typedef enum logic [1:0] {
    REG_COEF_CUBIC   = 2'd0,
    REG_COEF_SQUARE  = 2'd1,
    REG_COEF_QUARTIC = 2'd2
  } cfg_reg_t;

  // reduced angle in [-pi/2, pi/2], nano-radians, sign and magnitude
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } red_angle_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

// ===== hdl/scpf_front.sv =====
// ----------------------------------------------------------------------------
// scpf_front
// accepts angles, saturates, applies the cosine shift and reduces the range
// ----------------------------------------------------------------------------
module scpf_front import scpf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic signed [ANGLE_W-1:0] angle_micro,
  output logic                      push,
  input  logic                      full,
  output red_angle_t                push_data
);

  localparam int NF = 4;

  logic [NF-1:0] vld;
  logic [NF-1:0] en;

  logic signed [ANGLE_W-1:0] a_sat, a_cos;
  logic signed [ANGLE_W-1:0] s1_a, s2_a;
  logic                      s1_op;
  logic signed [NANO_W-1:0]  a_nano, x_wrap, x_refl, s3_x;

  // stall ripples back from the queue
  always_comb begin
    en[NF-1] = !vld[NF-1] || !full;
    for (int k = NF - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready = en[0];
  assign push     = vld[NF-1] && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NF; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: saturate, add pi/2 for cosine
  always_comb begin
    if (angle_micro > ANGLE_LIMIT) begin
      a_sat = ANGLE_LIMIT;
    end else if (angle_micro < -ANGLE_LIMIT) begin
      a_sat = -ANGLE_LIMIT;
    end else begin
      a_sat = angle_micro;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_a  <= op ? a_sat + HALF_PI_MICRO : a_sat;
      s1_op <= op;
    end
  end

  // stage 2: cosine wrap, truncated back to micro units
  always_comb begin
    a_cos = s1_a;
    if (s1_op) begin
      if (s1_a >= PI_MICRO_UP) begin
        a_cos = s1_a - ((s1_a >= TWO_PI_HI) ? TWO_PI_HI : TWO_PI_LO);
      end else if (s1_a <= -PI_MICRO_UP) begin
        a_cos = s1_a + ((s1_a >= -TWO_PI_LO) ? TWO_PI_LO : TWO_PI_HI);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) s2_a <= a_cos;
  end

  // stage 3: to nano-radians, wrap once into [-pi, pi]
  always_comb begin
    a_nano = NANO_W'(s2_a) * NANO_PER_MICRO;
    if (s2_a >= PI_MICRO_UP) begin
      x_wrap = a_nano - TWO_PI_NANO;
    end else if (s2_a <= -PI_MICRO_UP) begin
      x_wrap = a_nano + TWO_PI_NANO;
    end else begin
      x_wrap = a_nano;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) s3_x <= x_wrap;
  end

  // stage 4: reflect into [-pi/2, pi/2], split sign and magnitude
  always_comb begin
    if (s3_x > HALF_PI_NANO) begin
      x_refl = PI_NANO - s3_x;
    end else if (s3_x < -HALF_PI_NANO) begin
      x_refl = -PI_NANO - s3_x;
    end else begin
      x_refl = s3_x;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      push_data.neg <= x_refl[NANO_W-1];
      push_data.mag <= x_refl[NANO_W-1] ? MAG_W'(-x_refl) : MAG_W'(x_refl);
    end
  end

endmodule

// ===== hdl/scpf_queue.sv =====
// ----------------------------------------------------------------------------
// scpf_queue
// short queue of reduced angles between the front and the back
// ----------------------------------------------------------------------------
module scpf_queue import scpf_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  red_angle_t    push_data,
  input  logic          pop,
  output red_angle_t    pop_data,
  output queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  red_angle_t      mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign status.valid = (count != '0);
  assign status.full  = (count == CW'(DEPTH));
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/scpf_back.sv =====
// ----------------------------------------------------------------------------
// scpf_back
// Q conversion and polynomial evaluation pipeline with output register
// ----------------------------------------------------------------------------
module scpf_back import scpf_pkg::*; #(
  parameter int FRAC_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        pop,
  input  red_angle_t                  pop_data,
  input  logic signed [FRAC_BITS+1:0] c1,
  input  logic signed [FRAC_BITS+1:0] c2,
  input  logic signed [FRAC_BITS+1:0] c3,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_W-1:0]     value_micro
);

  localparam int NB  = 9;
  localparam int QW  = FRAC_BITS + 1;
  localparam int XW  = FRAC_BITS + 2;
  localparam int TW  = FRAC_BITS + 3;
  localparam int KW  = FRAC_BITS + 2;
  localparam int S1W = FRAC_BITS + 4;
  localparam int S2W = FRAC_BITS + 6;
  localparam int YW  = 64 - FRAC_BITS;
  localparam int RW  = FRAC_BITS + 2;
  localparam int P1W = MAG_W + RW;
  localparam int P2W = QW + 30;
  localparam int RSH = 31;
  // 2^(FRAC_BITS+31) / 1e9, rounded down
  localparam logic [RW-1:0] RECIP =
    RW'((64'd1 << (FRAC_BITS + RSH)) / 64'd1000000000);

  logic [NB-1:0] vld;
  logic [NB-1:0] en;

  // stage registers
  logic [P1W-1:0]         b1_p1;
  logic [MAG_W-1:0]       b1_mag, b2_mag;
  logic                   b1_neg, b2_neg;
  logic [QW-1:0]          b2_qe;
  logic [P2W-1:0]         b2_p2;
  logic signed [XW-1:0]   b3_xp, b4_xp, b5_xp, b6_xp;
  logic signed [TW-1:0]   b4_t, b5_t;
  logic signed [TW+KW-1:0]  b5_p3;
  logic signed [TW+S1W-1:0] b6_p4;
  logic signed [XW+S2W-1:0] b7_p5;
  logic                   b8_neg, b8_sat;
  logic [FRAC_BITS:0]     b8_mlo;

  // stage logic
  logic [QW-1:0]            qe_c, q_c;
  logic [P2W-1:0]           num_c, rem_c;
  logic signed [XW-1:0]     qs_c;
  logic signed [2*XW-1:0]   sq_c;
  logic signed [S1W-1:0]    s1_c;
  logic signed [63:0]       w4_c, w5_c;
  logic signed [S2W-1:0]    s2_c;
  logic signed [YW-1:0]     ys_c;
  logic [YW-1:0]            magy_c;
  logic [FRAC_BITS+20:0]    pr_c;
  logic [OUT_W-1:0]         sc_c, lim_c;

  always_comb begin
    en[NB-1] = !vld[NB-1] || out_ready;
    for (int k = NB - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pop       = en[0] && q_valid;
  assign out_valid = vld[NB-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= q_valid;
      for (int k = 1; k < NB; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // 1: quotient estimate by reciprocal
  always_ff @(posedge clk) begin
    if (en[0]) begin
      b1_p1  <= P1W'(pop_data.mag) * P1W'(RECIP);
      b1_mag <= pop_data.mag;
      b1_neg <= pop_data.neg;
    end
  end

  // 2: estimate back-multiplied by 1e9
  assign qe_c = b1_p1[RSH +: QW];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b2_qe  <= qe_c;
      b2_p2  <= P2W'(qe_c) * P2W'(NANO_PER_UNIT);
      b2_mag <= b1_mag;
      b2_neg <= b1_neg;
    end
  end

  // 3: one correction step, sign reapplied
  always_comb begin
    num_c = P2W'(b2_mag) << FRAC_BITS;
    rem_c = num_c - b2_p2;
    q_c   = b2_qe + QW'(rem_c >= P2W'(NANO_PER_UNIT));
    qs_c  = signed'({1'b0, q_c});
  end

  always_ff @(posedge clk) begin
    if (en[2]) b3_xp <= b2_neg ? -qs_c : qs_c;
  end

  // 4: t = x*x
  assign sq_c = b3_xp * b3_xp;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      b4_t  <= signed'(sq_c[2*FRAC_BITS+2:FRAC_BITS]);
      b4_xp <= b3_xp;
    end
  end

  // 5: t*c3
  always_ff @(posedge clk) begin
    if (en[4]) begin
      b5_p3 <= b4_t * c3;
      b5_t  <= b4_t;
      b5_xp <= b4_xp;
    end
  end

  // 6: s1 = (t*c3 >> f) + c2, then t*s1
  assign s1_c = S1W'(b5_p3 >>> FRAC_BITS) + S1W'(c2);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      b6_p4 <= b5_t * s1_c;
      b6_xp <= b5_xp;
    end
  end

  // 7: s2 = (t*s1 >> f) + c1, then x*s2; products wrap at 64 bits
  always_comb begin
    w4_c = 64'(b6_p4);
    s2_c = S2W'(w4_c >>> FRAC_BITS) + S2W'(c1);
  end

  always_ff @(posedge clk) begin
    if (en[6]) b7_p5 <= b6_xp * s2_c;
  end

  // 8: sign, magnitude and overrange
  always_comb begin
    w5_c   = 64'(b7_p5);
    ys_c   = YW'(w5_c >>> FRAC_BITS);
    magy_c = ys_c[YW-1] ? YW'(-ys_c) : YW'(ys_c);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      b8_neg <= ys_c[YW-1];
      b8_sat <= |magy_c[YW-1:FRAC_BITS+1];
      b8_mlo <= magy_c[FRAC_BITS:0];
    end
  end

  // 9: scale to micro units, clamp, output register
  always_comb begin
    pr_c  = (FRAC_BITS + 21)'(b8_mlo) * (FRAC_BITS + 21)'(MICRO_PER_UNIT);
    sc_c  = OUT_W'(pr_c[FRAC_BITS+20:FRAC_BITS]);
    lim_c = (b8_sat || (sc_c > OUT_LIMIT)) ? OUT_LIMIT : sc_c;
  end

  always_ff @(posedge clk) begin
    if (en[8]) value_micro <= b8_neg ? -signed'(lim_c) : signed'(lim_c);
  end

endmodule

// ===== hdl/sine_cosine_poly_fixed_unit.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_poly_fixed_unit
// fixed-point sine / cosine by an odd polynomial over a reduced angle
//
// input channel: in_valid / in_ready with op (0 sine, 1 cosine) and
//   angle_micro in micro-radians; angles beyond +-3pi saturate
// output channel: out_valid / out_ready with value_micro in millionths
// config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   coef_cubic, coef_square or coef_quartic, cfg_data is the Q20 value;
//   to be written only while no beat is in flight; the block does not enforce it
// throughput: one beat per cycle while out_ready is high; an input beat
//   passes the range-reduction front, then the queue and then the
//   multiplier pipeline of the back before it reaches out_valid
// stall: a held out_ready freezes the back, the queue soaks up the front
//   and then in_ready drops; nothing is lost or repeated
// reset: coefficients return to their defaults, all pipeline stages and
//   the queue empty at once; no clearing pass is needed
// ----------------------------------------------------------------------------
`include "sine_cosine_poly_fixed_unit_assert.svh"

module sine_cosine_poly_fixed_unit import scpf_pkg::*; #(
  parameter int FRAC_BITS   = 20,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic signed [ANGLE_W-1:0] angle_micro,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   value_micro,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [COEF_W-1:0]         cfg_data
);

  // rescaling of Q20 coefficients to the working fraction width
  localparam int UP = (FRAC_BITS >= 20) ? FRAC_BITS - 20 : 0;
  localparam int DN = (FRAC_BITS >= 20) ? 0 : 20 - FRAC_BITS;

  function automatic logic signed [FRAC_BITS+1:0] scale_coef(
    input logic signed [COEF_W-1:0] raw
  );
    logic signed [COEF_W+UP-1:0] up_v;
    up_v = (COEF_W + UP)'(raw) <<< UP;
    return (FRAC_BITS + 2)'(up_v >>> DN);
  endfunction

  // coefficient registers
  logic signed [COEF_W-1:0] coef_cubic, coef_square, coef_quartic;
  logic signed [FRAC_BITS+1:0] c1, c2, c3;

  // front to back queue
  logic          q_push, q_pop;
  red_angle_t    q_push_data, q_pop_data;
  queue_status_t q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_cubic   <= COEF_CUBIC_RST;
      coef_square  <= COEF_SQUARE_RST;
      coef_quartic <= COEF_QUARTIC_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COEF_CUBIC:   coef_cubic   <= signed'(cfg_data);
        REG_COEF_SQUARE:  coef_square  <= signed'(cfg_data);
        REG_COEF_QUARTIC: coef_quartic <= signed'(cfg_data);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign c1 = scale_coef(coef_cubic);
  assign c2 = scale_coef(coef_square);
  assign c3 = scale_coef(coef_quartic);

  // saturation, cosine shift, wrap and reflection
  scpf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .angle_micro (angle_micro),
    .push        (q_push),
    .full        (q_status.full),
    .push_data   (q_push_data)
  );

  scpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  // Q conversion and polynomial, ends in the output register
  scpf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_status.valid),
    .pop         (q_pop),
    .pop_data    (q_pop_data),
    .c1          (c1),
    .c2          (c2),
    .c3          (c3),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value_micro (value_micro)
  );

  // checks
  `SCPF_ASSERT_IMPLY(a_no_push_full, q_status.full, !q_push, "push into a full queue")
  `SCPF_ASSERT_IMPLY(a_no_pop_empty, q_pop, q_status.valid, "pop from an empty queue")
  `SCPF_ASSERT_NEXT(a_reset_empty, rst, !out_valid && !q_status.valid, "not empty after reset")
  `SCPF_ASSERT_IMPLY(a_out_range, out_valid, (value_micro <= 22'sd1048576) && (value_micro >= -22'sd1048576), "result beyond unit range")

endmodule

// ===== test/tb_sine_cosine_poly_fixed_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_cosine_poly_fixed_unit
// self-checking bench for the fixed-point sine / cosine unit
//
// angles and function selects go in over a valid / ready channel with random
// gaps; every result beat is checked against a bit-exact fixed-point
// prediction. coefficient sets are loaded between drained phases, from the
// reset values to the widest 22-bit patterns and random sets
// ----------------------------------------------------------------------------
module tb_sine_cosine_poly_fixed_unit;
  import scpf_pkg::*;

  localparam int FRAC_BITS    = 20;
  localparam int PIPE_LATENCY = 14;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1900;

  // config index that decodes to no register
  localparam logic [1:0] REG_SPARE = 2'd3;

  // range reduction constants in nano-radians
  localparam longint PI_N      = 64'sd3141592654;
  localparam longint HALF_PI_N = 64'sd1570796327;
  localparam longint TWO_PI_N  = 64'sd6283185307;
  localparam longint NANO_UNIT = 64'sd1000000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      op = 1'b0;
  logic signed [ANGLE_W-1:0] angle_micro = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [OUT_W-1:0]   value_micro;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = '0;
  logic [COEF_W-1:0]         cfg_data = '0;

  // local copy of the coefficient registers, updated on each config beat
  logic signed [COEF_W-1:0] model_c1 = COEF_CUBIC_RST;
  logic signed [COEF_W-1:0] model_c2 = COEF_SQUARE_RST;
  logic signed [COEF_W-1:0] model_c3 = COEF_QUARTIC_RST;

  // predicted results, oldest first
  logic signed [OUT_W-1:0] pending_values [$];

  // when set, that side never idles
  bit in_steady  = 1'b0;
  bit out_steady = 1'b0;

  int items_sent      = 0;
  int cos_sent        = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int settings_used   = 1;
  int cycle_count     = 0;

  sine_cosine_poly_fixed_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .angle_micro (angle_micro),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value_micro (value_micro),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------

  // one wrap by 2pi towards [-pi, pi]
  function automatic longint wrap_turn(input longint x);
    if (x > PI_N)
      return x - TWO_PI_N;
    else if (x < -PI_N)
      return x + TWO_PI_N;
    return x;
  endfunction

  // Q20 register value to the working fraction width
  function automatic longint coef_to_frac(input logic signed [COEF_W-1:0] c);
    longint v;
    v = longint'(c);
    if (FRAC_BITS >= 20)
      return v <<< (FRAC_BITS - 20);
    return v >>> (20 - FRAC_BITS);
  endfunction

  function automatic logic signed [OUT_W-1:0] poly_sine_micro(
    input logic fn_cos,
    input logic signed [ANGLE_W-1:0] ang
  );
    longint a, xn, q, c1, c2, c3, t, s1, s2, y;
    logic [63:0] mag, res;
    logic neg;
    a = longint'(ang);
    // saturate beyond +-3pi
    if (a > longint'(ANGLE_LIMIT))
      a = longint'(ANGLE_LIMIT);
    else if (a < -longint'(ANGLE_LIMIT))
      a = -longint'(ANGLE_LIMIT);
    // cosine: shift by pi/2, wrap, back to micro units truncated toward zero
    if (fn_cos)
      a = wrap_turn((a + longint'(HALF_PI_MICRO)) * 1000) / 1000;
    xn = wrap_turn(a * 1000);
    // reflect into [-pi/2, pi/2]
    if (xn > HALF_PI_N)
      xn = PI_N - xn;
    else if (xn < -HALF_PI_N)
      xn = -PI_N - xn;
    q = (xn * (longint'(1) <<< FRAC_BITS)) / NANO_UNIT;
    c1 = coef_to_frac(model_c1);
    c2 = coef_to_frac(model_c2);
    c3 = coef_to_frac(model_c3);
    // products wrap at 64 bits, then shift arithmetically
    t  = (q * q) >>> FRAC_BITS;
    s1 = ((t * c3) >>> FRAC_BITS) + c2;
    s2 = ((t * s1) >>> FRAC_BITS) + c1;
    y  = (q * s2) >>> FRAC_BITS;
    neg = (y < 0);
    mag = neg ? -y : y;
    if (mag >= (64'd2 << FRAC_BITS)) begin
      res = 64'(OUT_LIMIT);
    end else begin
      res = (mag * 64'd1000000) >> FRAC_BITS;
      if (res > OUT_LIMIT)
        res = 64'(OUT_LIMIT);
    end
    if (neg)
      res = -res;
    return res[OUT_W-1:0];
  endfunction

  // ------------------------------------------------------------------
  // scoreboard: config tracking, input capture and result checking,
  // all on the same edge so the order between them is fixed
  // ------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    logic signed [OUT_W-1:0] want;
    if (!rst) begin
      // coefficient writes land before any beat that follows them
      if (cfg_valid && cfg_ready === 1'b1) begin
        case (cfg_index)
          REG_COEF_CUBIC:   model_c1 = cfg_data;
          REG_COEF_SQUARE:  model_c2 = cfg_data;
          REG_COEF_QUARTIC: model_c3 = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready === 1'b1) begin
        pending_values.push_back(poly_sine_micro(op, angle_micro));
        items_sent++;
        if (op)
          cos_sent++;
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (pending_values.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0d",
                   $time, value_micro);
          mismatches++;
        end else begin
          want = pending_values.pop_front();
          results_checked++;
          if (value_micro !== want) begin
            $display("%0t: value_micro mismatch, expected %0d, actual %0d",
                     $time, want, value_micro);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_values.size());
      $display("tb_sine_cosine_poly_fixed_unit: FAIL");
      $finish;
    end
  end

  // receiver: random stall before each result beat unless out_steady is set
  initial begin : result_sink
    int gap;
    @(posedge clk);
    while (rst)
      @(posedge clk);
    forever begin
      gap = out_steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // ------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------

  // one angle beat; valid stays high afterwards so a following beat can
  // go straight on, the caller lowers it through wait_drained
  task automatic send_angle(input logic fn_cos, input logic signed [ANGLE_W-1:0] ang);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= fn_cos;
    angle_micro <= ang;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // stop sending, wait for every result, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_values.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // full coefficient set, optionally followed by a write to the spare index
  task automatic load_coefs(
    input logic [COEF_W-1:0] c1,
    input logic [COEF_W-1:0] c2,
    input logic [COEF_W-1:0] c3,
    input bit                spare
  );
    logic [31:0] rnd;
    cfg_write(REG_COEF_CUBIC, c1);
    cfg_write(REG_COEF_SQUARE, c2);
    cfg_write(REG_COEF_QUARTIC, c3);
    if (spare) begin
      rnd = $urandom();
      cfg_write(REG_SPARE, rnd[COEF_W-1:0]);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // mostly in-range angles, some near the wrap / reflect points, some raw
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int marks [10] = '{0, 1570796, 1570797, 3141592, 3141593,
                       4712389, 6283185, 6283186, 7853982, 9424777};
    int v;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      v = $urandom();
    end else if (pick <= 2) begin
      v = marks[$urandom_range(0, 9)] + $urandom_range(0, 6) - 3;
      if ($urandom_range(0, 1))
        v = -v;
    end else begin
      v = $urandom_range(0, 18849554) - 9424777;
    end
    return v[ANGLE_W-1:0];
  endfunction

  // near-nominal, in-range or any 22-bit pattern
  function automatic logic [COEF_W-1:0] random_coef(input logic signed [COEF_W-1:0] nominal);
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom();
      1:       v = $urandom_range(0, 2097152) - 1048576;
      default: v = nominal + $urandom_range(0, 4000) - 2000;
    endcase
    return v[COEF_W-1:0];
  endfunction

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // reset coefficients: field extremes, saturation, wrap and reflect edges
  task automatic test_reset_defaults();
    int  dir_angle [14] = '{0, 0, 9424777, -9424777, 16777215, -16777216,
                            1570796, 1570797, -1570797, 3141593, -3141593,
                            1570797, -9424777, 7853981};
    bit  dir_cos   [14] = '{0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 1, 1};
    int  i;
    for (i = 0; i < 14; i++)
      send_angle(dir_cos[i], dir_angle[i][ANGLE_W-1:0]);
    wait_drained();
  endtask

  // widest coefficient patterns; large gains drive the result into saturation
  task automatic test_coef_extremes();
    int set_c1 [4] = '{2097151, -2097152, 1048576, 0};
    int set_c2 [4] = '{2097151, -2097152, -1048576, 0};
    int set_c3 [4] = '{2097151, -2097152, 1048576, 0};
    int s;
    for (s = 0; s < 4; s++) begin
      // spare index written on the first set, must leave the others alone
      load_coefs(set_c1[s][COEF_W-1:0], set_c2[s][COEF_W-1:0],
                 set_c3[s][COEF_W-1:0], s == 0);
      send_angle(1'b0, 25'sd1570796);
      send_angle(1'b0, -25'sd1234567);
      send_angle(1'b1, 25'sd0);
      wait_drained();
    end
  endtask

  // random stream over several coefficient sets; one phase with neither
  // side idling, one with a steady sender against a stalling receiver
  task automatic test_random_stream(input int total);
    int seg;
    int i;
    int per_seg;
    int pause_at;
    per_seg = total / 6;
    for (seg = 0; seg < 6; seg++) begin
      if (seg == 0)
        load_coefs(COEF_CUBIC_RST, COEF_SQUARE_RST, COEF_QUARTIC_RST, 1'b0);
      else
        load_coefs(random_coef(COEF_CUBIC_RST), random_coef(COEF_SQUARE_RST),
                   random_coef(COEF_QUARTIC_RST), seg == 4);
      in_steady  = (seg == 2 || seg == 3);
      out_steady = (seg == 2);
      pause_at   = $urandom_range(1, per_seg - 1);
      for (i = 0; i < per_seg; i++) begin
        // sender holds off until everything in flight has come back
        if (i == pause_at)
          wait_drained();
        send_angle(1'($urandom_range(0, 1)), random_angle());
      end
      wait_drained();
    end
    in_steady  = 1'b0;
    out_steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_coef_extremes();
    test_random_stream(RANDOM_ITEMS);
    wait_drained();

    $display("covered %0d angle beats (%0d cosine) under %0d coefficient sets",
             items_sent, cos_sent, settings_used);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("tb_sine_cosine_poly_fixed_unit: PASS");
    end else begin
      $display("tb_sine_cosine_poly_fixed_unit: FAIL");
    end
    $finish;
  end

endmodule
